@@ sv/mqsr_pkg.sv @@
package mqsr_pkg;

    localparam int NUM_QUEUES = 8;
    localparam int RING_SLOTS = 256;
    localparam int SLOT_BYTES = 2048;

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW = $clog2(RING_SLOTS);
    localparam int RAM_DEPTH = NUM_QUEUES * RING_SLOTS;
    localparam int AW = $clog2(RAM_DEPTH);
    localparam int LEN_W = 12;

    localparam logic [2:0] REQ_ENQUEUE = 3'd0;
    localparam logic [2:0] REQ_PEEK    = 3'd1;
    localparam logic [2:0] REQ_POP     = 3'd2;
    localparam logic [2:0] REQ_STATUS  = 3'd3;
    localparam logic [2:0] REQ_FLUSH   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [2:0]       queue_id;
        logic [LEN_W-1:0] entry_length;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       slot_index;
        logic [LEN_W-1:0] length_out;
        logic [7:0]       occupancy;
        logic             is_full;
        logic             is_empty;
    } t_rsp;

    // Ids at or above the queue count wrap around by repeated subtraction.
    function automatic logic [QW-1:0] q_reduce(input logic [2:0] id);
        logic [2:0] v;
        v = id;
        for (int i = 0; i < 8; i++) begin
            if (int'(v) >= NUM_QUEUES) begin
                v = 3'(int'(v) - NUM_QUEUES);
            end
        end
        return QW'(v);
    endfunction

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (int'(p) == RING_SLOTS - 1) ? '0 : PW'(int'(p) + 1);
    endfunction

    function automatic logic [PW-1:0] ring_count(input logic [PW-1:0] head,
                                                  input logic [PW-1:0] tail);
        return (head >= tail) ? PW'(head - tail)
                              : PW'(int'(head) + RING_SLOTS - int'(tail));
    endfunction

endpackage

@@ sv/mqsr_ram.sv @@
module mqsr_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/multi_queue_slot_ring.sv @@
// Bank of independent circular queues, one per terminal, each over a fixed
// ring of slots that store one length per slot. One slot per ring is always
// left free, so a queue holds at most one entry less than its slot count.
//
// Requests arrive as beats on the i_valid / o_ready channel and every request
// yields exactly one result beat on the o_valid / i_ready channel. A request
// enqueues, peeks, pops, reports status or flushes the queue it names.
//
// Between the accepting edge and o_valid, the first stage updates the queue
// pointers and launches the slot memory access, and the second collects the
// registered memory read. One request is accepted per cycle while the receiver
// does not stall; pointer updates land at the accepting edge, so back-to-back
// requests to the same queue need no forwarding.
//
// Reset zeroes all head and tail pointers and empties both stages. The slot
// memory is not cleared; an entry is only read after it has been written.
// When the receiver stalls, the result stays in the output register and the
// first stage still holds one more beat before o_ready drops.
module multi_queue_slot_ring
    import mqsr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    // Pointer files, one entry per queue.
    logic [PW-1:0] r_head [NUM_QUEUES];
    logic [PW-1:0] r_tail [NUM_QUEUES];

    // First stage: the result minus the peeked length.
    logic r_a_valid;
    logic r_a_peek;
    t_rsp r_a_rsp;

    // Second stage: the output register.
    logic r_b_valid;
    t_rsp r_b_rsp;
    t_rsp n_b_rsp;

    logic             in_acc;
    logic             a_move;
    logic [QW-1:0]    q;
    logic [LEN_W-1:0] len;
    logic [PW-1:0]    head_cur;
    logic [PW-1:0]    tail_cur;
    logic [PW-1:0]    head_new;
    logic [PW-1:0]    tail_new;
    logic [PW-1:0]    occ;
    logic [PW-1:0]    mem_ptr;
    logic             full_cur;
    logic             empty_cur;
    logic             peek_ok;
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_addr;
    logic [LEN_W-1:0] mem_rdata;
    t_rsp             rsp;

    // The first stage advances whenever the output register is free or is
    // being drained this cycle; a new beat enters whenever the first stage
    // is empty or advances.
    assign a_move  = r_a_valid && (!r_b_valid || i_ready);
    assign o_ready = !r_a_valid || a_move;
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        q         = q_reduce(i_req.queue_id);
        len       = (int'(i_req.entry_length) > SLOT_BYTES) ? LEN_W'(SLOT_BYTES)
                                                            : i_req.entry_length;
        head_cur  = r_head[q];
        tail_cur  = r_tail[q];
        head_new  = head_cur;
        tail_new  = tail_cur;
        full_cur  = (ring_next(head_cur) == tail_cur);
        empty_cur = (head_cur == tail_cur);
        peek_ok   = 1'b0;
        mem_we    = 1'b0;
        mem_ptr   = head_cur;
        rsp       = '0;
        rsp.status = ST_OK;

        unique case (i_req.req_type)
            REQ_ENQUEUE: begin
                if (full_cur) begin
                    rsp.status = ST_FULL;
                end else begin
                    rsp.slot_index = 8'(head_cur);
                    head_new       = ring_next(head_cur);
                    mem_we         = 1'b1;
                end
            end
            REQ_PEEK: begin
                if (empty_cur) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.slot_index = 8'(tail_cur);
                    mem_ptr        = tail_cur;
                    peek_ok        = 1'b1;
                end
            end
            REQ_POP: begin
                if (empty_cur) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.slot_index = 8'(tail_cur);
                    tail_new       = ring_next(tail_cur);
                end
            end
            REQ_FLUSH: begin
                head_new = '0;
                tail_new = '0;
            end
            default: begin
                // Status and the unused codes only report.
            end
        endcase

        // Flags and occupancy describe the queue after the request.
        occ           = ring_count(head_new, tail_new);
        rsp.occupancy = 8'(occ);
        rsp.is_full   = (ring_next(head_new) == tail_new);
        rsp.is_empty  = (head_new == tail_new);
    end

    assign mem_re   = in_acc && peek_ok;
    assign mem_addr = AW'(int'(q) * RING_SLOTS + int'(mem_ptr));

    // Slot lengths of all queues; queue id selects the row, pointer the slot.
    mqsr_ram #(
        .WIDTH (LEN_W),
        .DEPTH (RAM_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (len),
        .o_rdata (mem_rdata)
    );

    // The peeked length joins the result as it moves to the output register.
    always_comb begin
        n_b_rsp            = r_a_rsp;
        n_b_rsp.length_out = r_a_peek ? mem_rdata : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_head[q] <= head_new;
                r_tail[q] <= tail_new;
            end
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (a_move) begin
                r_b_valid <= 1'b1;
            end else if (i_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_rsp  <= rsp;
            r_a_peek <= peek_ok;
        end
        if (a_move) begin
            // The memory read data holds until the next peek enters, which
            // cannot happen before this stage moves on.
            r_b_rsp <= n_b_rsp;
        end
    end

    assign o_valid = r_b_valid;
    assign o_rsp   = r_b_rsp;

    // A stalled first stage keeps its beat.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !a_move |=> r_a_valid)
        else $error("first stage lost a beat while stalled");

    // The slot memory is read only for an accepted, successful peek.
    ram_read_only_on_peek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |-> i_valid && o_ready && i_req.req_type == REQ_PEEK && !empty_cur)
        else $error("slot memory read outside a peek");

    // A rejected enqueue leaves the head pointer untouched.
    full_enqueue_keeps_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_req.req_type == REQ_ENQUEUE && full_cur
        |=> r_head[$past(q)] == $past(head_cur))
        else $error("head moved on a rejected enqueue");

    // A rejected request reports no slot.
    reject_has_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_a_rsp.status != ST_OK |-> r_a_rsp.slot_index == '0 && !r_a_peek)
        else $error("rejected request carries a slot");

    // Full and empty never hold together for one queue.
    flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> !(r_a_rsp.is_full && r_a_rsp.is_empty))
        else $error("queue reported both full and empty");

endmodule
